### rtl/bmh_pkg.sv
// ----------------------------------------------------------------------------
// Binary min-heap package
// Shared defaults, operation codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bmh_pkg;

    // Default sizing of the heap.
    localparam int DEF_CAPACITY = 1024;
    localparam int DEF_KEY_BITS = 32;
    localparam int DEF_TAG_BITS = 16;

    // Operation carried by one command.
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    // Status reported with every result.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

endpackage

`default_nettype wire

### rtl/binary_min_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Binary min-heap priority queue core
// Array-based min-heap of (key, tag) entries held in a dual-read RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                  Direction  Transfer when
//  --------  ---------------------------------------  ---------  --------------------
//  command   start, busy, i_op, i_key, i_tag          in         start && !busy
//  result    o_done, o_status, o_popped_*, o_top_*,   out        o_done (one cycle)
//            o_entry_count, o_is_empty, o_is_full
//
//  A push into a non-empty heap reads the parent of the new slot, then climbs in
//  S_UP, moving each parent whose key is not smaller down a level, until a
//  smaller parent or the root (through S_FIN) is met. A pop of two or more
//  entries fetches the last entry in S_GOT_LAST, then sinks it in S_DN, moving
//  the chosen child up a level, until that child is larger or no child is left
//  (through S_FIN); a pop that leaves a single entry ends in S_GOT_LAST. The
//  single RAM write port moves one entry per cycle. Refused pushes, pops on an
//  empty heap, a push into an empty heap and the pop of the only entry finish
//  in S_IDLE with no heap walk. The result strobe o_done rises in the cycle
//  after the last cycle of work, and busy falls in that same cycle, so a new
//  command may be transferred while a result is shown. The receiver cannot
//  stall. Reset is synchronous and active low and empties the heap at once.
//
`default_nettype none

module binary_min_heap_priority_queue_core #(
    parameter int CAPACITY = bmh_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = bmh_pkg::DEF_KEY_BITS,
    parameter int TAG_BITS = bmh_pkg::DEF_TAG_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Command channel.
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_op,
    input  wire logic [KEY_BITS-1:0]              i_key,
    input  wire logic [TAG_BITS-1:0]              i_tag,
    // Result channel.
    output logic                                  o_done,
    output logic [1:0]                            o_status,
    output logic [KEY_BITS-1:0]                   o_popped_key,
    output logic [TAG_BITS-1:0]                   o_popped_tag,
    output logic                                  o_top_valid,
    output logic [KEY_BITS-1:0]                   o_top_key,
    output logic [TAG_BITS-1:0]                   o_top_tag,
    output logic [$clog2(CAPACITY+1)-1:0]         o_entry_count,
    output logic                                  o_is_empty,
    output logic                                  o_is_full
);

    // Positions are 1-based (root is 1, children of p are 2p and 2p+1);
    // RAM address is position minus one.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int EW    = KEY_BITS + TAG_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_GOT_LAST,
        S_DN,
        S_FIN
    } t_state;

    t_state                 r_state,    n_state;
    logic [CNT_W-1:0]       r_pos,      n_pos;
    logic [CNT_W-1:0]       r_count,    n_count;
    logic [KEY_BITS-1:0]    r_key,      n_key;
    logic [TAG_BITS-1:0]    r_tag,      n_tag;
    logic [KEY_BITS-1:0]    r_top_key,  n_top_key;
    logic [TAG_BITS-1:0]    r_top_tag,  n_top_tag;
    logic [KEY_BITS-1:0]    r_pop_key,  n_pop_key;
    logic [TAG_BITS-1:0]    r_pop_tag,  n_pop_tag;
    bmh_pkg::t_status       r_status,   n_status;
    logic                   r_done,     n_done;

    // RAM access, expressed in heap positions.
    logic                   wr_en;
    logic [CNT_W-1:0]       wr_pos;
    logic [EW-1:0]          wr_data;
    logic [CNT_W-1:0]       rd_pos_a;
    logic [CNT_W-1:0]       rd_pos_b;
    logic [EW-1:0]          rd_data_a;
    logic [EW-1:0]          rd_data_b;

    // Sift-down helpers derived from the current position.
    logic [CNT_W:0]         child_x;
    logic [CNT_W:0]         count_x;
    logic                   take_right;
    logic [EW-1:0]          child_data;
    logic [CNT_W:0]         pick_x;
    logic [CNT_W-1:0]       pick_pos;
    logic [CNT_W:0]         next_child_x;
    logic [CNT_W-1:0]       parent_pos;
    logic                   is_full;

    bmh_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (AW'(wr_pos - CNT_W'(1))),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (AW'(rd_pos_a - CNT_W'(1))),
        .i_rd_addr_b (AW'(rd_pos_b - CNT_W'(1))),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    assign is_full      = (r_count == CNT_W'(CAPACITY));
    assign parent_pos   = r_pos >> 1;
    assign child_x      = {r_pos, 1'b0};
    assign count_x      = {1'b0, r_count};
    // On a tie between the children the right one is taken.
    assign take_right   = (child_x < count_x) &&
                          (rd_data_a[EW-1:TAG_BITS] >= rd_data_b[EW-1:TAG_BITS]);
    assign child_data   = take_right ? rd_data_b : rd_data_a;
    assign pick_x       = child_x + {{CNT_W{1'b0}}, take_right};
    assign pick_pos     = pick_x[CNT_W-1:0];
    assign next_child_x = {pick_pos, 1'b0};

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_count   = r_count;
        n_key     = r_key;
        n_tag     = r_tag;
        n_top_key = r_top_key;
        n_top_tag = r_top_tag;
        n_pop_key = r_pop_key;
        n_pop_tag = r_pop_tag;
        n_status  = r_status;
        n_done    = 1'b0;
        wr_en     = 1'b0;
        wr_pos    = r_pos;
        wr_data   = {r_key, r_tag};
        rd_pos_a  = r_pos;
        rd_pos_b  = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_pop_key = '0;
                    n_pop_tag = '0;
                    n_status  = bmh_pkg::STATUS_OK;
                    if (i_op == bmh_pkg::OP_PUSH) begin
                        if (is_full) begin
                            n_status = bmh_pkg::STATUS_FULL;
                            n_done   = 1'b1;
                        end else if (r_count == '0) begin
                            // First entry goes straight to the root.
                            n_count = CNT_W'(1);
                            wr_en   = 1'b1;
                            wr_pos  = CNT_W'(1);
                            wr_data = {i_key, i_tag};
                            n_done  = 1'b1;
                        end else begin
                            n_count  = r_count + CNT_W'(1);
                            n_pos    = r_count + CNT_W'(1);
                            n_key    = i_key;
                            n_tag    = i_tag;
                            rd_pos_a = (r_count + CNT_W'(1)) >> 1;
                            n_state  = S_UP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = bmh_pkg::STATUS_EMPTY;
                            n_done   = 1'b1;
                        end else begin
                            n_pop_key = r_top_key;
                            n_pop_tag = r_top_tag;
                            n_count   = r_count - CNT_W'(1);
                            if (r_count == CNT_W'(1)) begin
                                n_done = 1'b1;
                            end else begin
                                // Fetch the last entry; it refills the root.
                                rd_pos_a = r_count;
                                n_pos    = CNT_W'(1);
                                n_state  = S_GOT_LAST;
                            end
                        end
                    end
                end
            end

            S_UP: begin
                // rd_data_a holds the parent of r_pos.
                if (rd_data_a[EW-1:TAG_BITS] >= r_key) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_a;
                    n_pos   = parent_pos;
                    if (parent_pos == CNT_W'(1)) begin
                        n_state = S_FIN;
                    end else begin
                        rd_pos_a = parent_pos >> 1;
                    end
                end else begin
                    wr_en   = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_GOT_LAST: begin
                n_key = rd_data_a[EW-1:TAG_BITS];
                n_tag = rd_data_a[TAG_BITS-1:0];
                if (child_x <= count_x) begin
                    rd_pos_a = child_x[CNT_W-1:0];
                    rd_pos_b = child_x[CNT_W-1:0] + CNT_W'(1);
                    n_state  = S_DN;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_a;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_DN: begin
                // rd_data_a and rd_data_b hold the children of r_pos.
                if (r_key < child_data[EW-1:TAG_BITS]) begin
                    wr_en   = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = child_data;
                    n_pos   = pick_pos;
                    if (next_child_x <= count_x) begin
                        rd_pos_a = next_child_x[CNT_W-1:0];
                        rd_pos_b = next_child_x[CNT_W-1:0] + CNT_W'(1);
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end

            S_FIN: begin
                wr_en   = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Keep a copy of the root so the top is known without a RAM read.
        if (wr_en && (wr_pos == CNT_W'(1))) begin
            n_top_key = wr_data[EW-1:TAG_BITS];
            n_top_tag = wr_data[TAG_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_pos     <= n_pos;
        r_key     <= n_key;
        r_tag     <= n_tag;
        r_top_key <= n_top_key;
        r_top_tag <= n_top_tag;
        r_pop_key <= n_pop_key;
        r_pop_tag <= n_pop_tag;
        r_status  <= n_status;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_popped_key  = r_pop_key;
    assign o_popped_tag  = r_pop_tag;
    assign o_top_valid   = (r_count != '0);
    assign o_top_key     = (r_count != '0) ? r_top_key : '0;
    assign o_top_tag     = (r_count != '0) ? r_top_tag : '0;
    assign o_entry_count = r_count;
    assign o_is_empty    = (r_count == '0);
    assign o_is_full     = is_full;

    // A result is only shown once the heap walk has finished.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while a heap walk is in progress");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == bmh_pkg::OP_PUSH) && !is_full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted push did not add one entry");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == bmh_pkg::OP_POP) && (r_count != '0))
        |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("accepted pop did not remove one entry");

    a_up_below_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |-> (r_pos >= CNT_W'(2)))
        else $error("sift-up compare at the root");

    a_dn_has_child: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN) |-> (child_x <= count_x))
        else $error("sift-down compare without a child");

endmodule

`default_nettype wire

### rtl/bmh_ram.sv
// ----------------------------------------------------------------------------
// Binary min-heap entry store
// Synchronous RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_ram #(
    parameter int DEPTH = bmh_pkg::DEF_CAPACITY,
    parameter int WIDTH = bmh_pkg::DEF_KEY_BITS + bmh_pkg::DEF_TAG_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

### bench/binary_min_heap_priority_queue_core_tb.sv
// ----------------------------------------------------------------------------
// Binary min-heap priority queue core testbench
// Sends push and pop commands through the start/busy handshake and checks
// every result strobe against a heap predictor kept inside the bench. The
// predictor breaks ties on equal keys the same way the block does, so the
// tags reported at the top and by each pop are checked exactly.
// ----------------------------------------------------------------------------

module binary_min_heap_priority_queue_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = bmh_pkg::DEF_CAPACITY;
    localparam int KEY_BITS   = bmh_pkg::DEF_KEY_BITS;
    localparam int TAG_BITS   = bmh_pkg::DEF_TAG_BITS;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    // Idle time, well above what the slowest command takes, whenever the bench
    // waits for the block to settle.
    localparam int SETTLE_CYCLES = 2 * $clog2(CAPACITY) + 8;

    // Far above the slowest correct run: about 2200 commands, each with its work
    // and a gap.
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam int RANDOM_COMMANDS = 100;

    // One result as the block reports it.
    typedef struct packed {
        bmh_pkg::t_status      status;
        logic [KEY_BITS-1:0]   popped_key;
        logic [TAG_BITS-1:0]   popped_tag;
        logic                  top_valid;
        logic [KEY_BITS-1:0]   top_key;
        logic [TAG_BITS-1:0]   top_tag;
        logic [COUNT_BITS-1:0] entry_count;
        logic                  is_empty;
        logic                  is_full;
    } t_heap_result;

    // Key patterns used by the stimulus. Narrow and edge keys force many
    // equal-key comparisons, which is where tie handling shows up.
    typedef enum int {
        KEYS_WIDE,
        KEYS_NARROW,
        KEYS_EDGE,
        KEYS_HIGH
    } t_key_mix;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs. Every input has a known value at time 0.
    // ------------------------------------------------------------------------
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  i_op    = 1'b0;
    logic [KEY_BITS-1:0]   i_key   = '0;
    logic [TAG_BITS-1:0]   i_tag   = '0;

    logic                  busy;
    logic                  o_done;
    logic [1:0]            o_status;
    logic [KEY_BITS-1:0]   o_popped_key;
    logic [TAG_BITS-1:0]   o_popped_tag;
    logic                  o_top_valid;
    logic [KEY_BITS-1:0]   o_top_key;
    logic [TAG_BITS-1:0]   o_top_tag;
    logic [COUNT_BITS-1:0] o_entry_count;
    logic                  o_is_empty;
    logic                  o_is_full;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    binary_min_heap_priority_queue_core #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_tag         (i_tag),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_popped_key  (o_popped_key),
        .o_popped_tag  (o_popped_tag),
        .o_top_valid   (o_top_valid),
        .o_top_key     (o_top_key),
        .o_top_tag     (o_top_tag),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    // ------------------------------------------------------------------------
    // Heap predictor. Slot 1 is the root and the children of slot i sit at
    // 2i and 2i+1. Only slots up to heap_fill are ever read.
    // ------------------------------------------------------------------------
    logic [KEY_BITS-1:0] heap_keys [1:CAPACITY];
    logic [TAG_BITS-1:0] heap_tags [1:CAPACITY];
    int unsigned         heap_fill = 0;

    // Results predicted for accepted commands, oldest first.
    t_heap_result predicted_results [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 0;

    function automatic t_heap_result heap_model_step(bmh_pkg::t_op op,
                                                     logic [KEY_BITS-1:0] key,
                                                     logic [TAG_BITS-1:0] tag);
        t_heap_result        res;
        int unsigned         slot;
        int unsigned         kid;
        logic [KEY_BITS-1:0] last_key;
        logic [TAG_BITS-1:0] last_tag;

        res        = '0;
        res.status = bmh_pkg::STATUS_OK;
        if (op == bmh_pkg::OP_PUSH) begin
            if (heap_fill >= CAPACITY) begin
                res.status = bmh_pkg::STATUS_FULL;
            end else begin
                // Sift up: an equal-keyed parent moves down as well, so the
                // newest of several equal keys ends up nearest the root.
                heap_fill++;
                slot = heap_fill;
                while (slot != 1 && heap_keys[slot / 2] >= key) begin
                    heap_keys[slot] = heap_keys[slot / 2];
                    heap_tags[slot] = heap_tags[slot / 2];
                    slot = slot / 2;
                end
                heap_keys[slot] = key;
                heap_tags[slot] = tag;
            end
        end else if (heap_fill == 0) begin
            res.status = bmh_pkg::STATUS_EMPTY;
        end else begin
            res.popped_key = heap_keys[1];
            res.popped_tag = heap_tags[1];
            last_key       = heap_keys[heap_fill];
            last_tag       = heap_tags[heap_fill];
            heap_fill--;
            slot = 1;
            kid  = 2;
            // Sift down: the right child wins a tie between children, and the
            // moved entry only stops above a strictly larger child.
            while (kid <= heap_fill) begin
                if (kid < heap_fill && heap_keys[kid] >= heap_keys[kid + 1]) begin
                    kid++;
                end
                if (last_key < heap_keys[kid]) begin
                    break;
                end
                heap_keys[slot] = heap_keys[kid];
                heap_tags[slot] = heap_tags[kid];
                slot = kid;
                kid  = kid * 2;
            end
            if (heap_fill != 0) begin
                heap_keys[slot] = last_key;
                heap_tags[slot] = last_tag;
            end
        end

        res.top_valid   = (heap_fill != 0);
        res.top_key     = (heap_fill != 0) ? heap_keys[1] : '0;
        res.top_tag     = (heap_fill != 0) ? heap_tags[1] : '0;
        res.entry_count = heap_fill[COUNT_BITS-1:0];
        res.is_empty    = (heap_fill == 0);
        res.is_full     = (heap_fill >= CAPACITY);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking. The receiver cannot stall, so every o_done cycle is a
    // transfer and is compared with the oldest prediction.
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (predicted_results.size() == 0) begin
                $error("o_done: expected no result, actual result with status %0d",
                       o_status);
                mismatch_count++;
            end else begin
                want = predicted_results.pop_front();
                check_field("o_done",      64'(1'b1),             64'(o_done));
                check_field("status",      64'(want.status),      64'(o_status));
                check_field("popped_key",  64'(want.popped_key),  64'(o_popped_key));
                check_field("popped_tag",  64'(want.popped_tag),  64'(o_popped_tag));
                check_field("top_valid",   64'(want.top_valid),   64'(o_top_valid));
                check_field("top_key",     64'(want.top_key),     64'(o_top_key));
                check_field("top_tag",     64'(want.top_tag),     64'(o_top_tag));
                check_field("entry_count", 64'(want.entry_count), 64'(o_entry_count));
                check_field("is_empty",    64'(want.is_empty),    64'(o_is_empty));
                check_field("is_full",     64'(want.is_full),     64'(o_is_full));
            end
        end
    end

    // A hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Command side.
    // ------------------------------------------------------------------------

    // Presents one command and holds it until the block takes it. The caller
    // is always just past a rising edge. start is left high so that the next
    // command can follow in the very next cycle.
    task automatic send_cmd(bmh_pkg::t_op op, logic [KEY_BITS-1:0] key,
                            logic [TAG_BITS-1:0] tag);
        start <= 1'b1;
        i_op  <= op;
        i_key <= key;
        i_tag <= tag;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        predicted_results.push_back(heap_model_step(op, key, tag));
    endtask

    // Bursts of back-to-back transfers separated by random gaps. Some bursts
    // have no gap after them at all. The data lines carry noise while start is
    // low, which the block must ignore.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                start <= 1'b0;
                i_op  <= 1'($urandom_range(0, 1));
                i_key <= KEY_BITS'($urandom);
                i_tag <= TAG_BITS'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stops sending until every predicted result has arrived, then lets the
    // block sit idle for a while.
    task automatic drain_results();
        start <= 1'b0;
        while (predicted_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key(t_key_mix mix);
        logic [KEY_BITS-1:0] key;
        case (mix)
            KEYS_NARROW: begin
                key = KEY_BITS'($urandom_range(0, 15));
            end
            KEYS_EDGE: begin
                case ($urandom_range(0, 3))
                    0:       key = '0;
                    1:       key = '1;
                    2:       key = {1'b0, {(KEY_BITS-1){1'b1}}};
                    default: key = {1'b1, {(KEY_BITS-1){1'b0}}};
                endcase
            end
            KEYS_HIGH: begin
                key = ~KEY_BITS'($urandom_range(0, 15));
            end
            default: begin
                key = KEY_BITS'($urandom);
            end
        endcase
        return key;
    endfunction

    function automatic t_key_mix pick_mix();
        return t_key_mix'($urandom_range(0, 3));
    endfunction

    function automatic logic [TAG_BITS-1:0] pick_tag();
        return TAG_BITS'($urandom_range(0, (1 << TAG_BITS) - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Pop on an empty heap, extreme keys and tags, and runs of equal keys that
    // exercise the tie rules on both the way up and the way down. Commands go
    // back to back with no gaps.
    task automatic test_edges_and_ties();
        send_cmd(bmh_pkg::OP_POP,  '0, '0);
        send_cmd(bmh_pkg::OP_PUSH, '1, '1);
        send_cmd(bmh_pkg::OP_PUSH, '0, '0);
        send_cmd(bmh_pkg::OP_PUSH, '0, TAG_BITS'(1));
        send_cmd(bmh_pkg::OP_PUSH, KEY_BITS'(5), TAG_BITS'(16'hAAAA));
        send_cmd(bmh_pkg::OP_PUSH, KEY_BITS'(5), TAG_BITS'(16'h5555));
        send_cmd(bmh_pkg::OP_PUSH, KEY_BITS'(5), TAG_BITS'(16'h1234));
        send_cmd(bmh_pkg::OP_PUSH, '1, '0);
        send_cmd(bmh_pkg::OP_PUSH, {1'b0, {(KEY_BITS-1){1'b1}}},
                 {1'b1, {(TAG_BITS-1){1'b0}}});
        repeat (8) send_cmd(bmh_pkg::OP_POP, '0, '0);
        send_cmd(bmh_pkg::OP_POP,  '1, '1);
    endtask

    // Fills the heap to capacity, tries to push past it, swaps one entry out
    // and in at the full mark, then empties the heap and pops once more.
    task automatic test_fill_and_overflow();
        t_key_mix mix;
        while (heap_fill < CAPACITY) begin
            mix = pick_mix();
            send_cmd(bmh_pkg::OP_PUSH, pick_key(mix), pick_tag());
            pace();
        end
        repeat (3) begin
            send_cmd(bmh_pkg::OP_PUSH, KEY_BITS'($urandom), pick_tag());
            pace();
        end
        send_cmd(bmh_pkg::OP_POP,  '0, '0);
        send_cmd(bmh_pkg::OP_PUSH, '0, pick_tag());
        send_cmd(bmh_pkg::OP_PUSH, '1, pick_tag());
        while (heap_fill > 0) begin
            send_cmd(bmh_pkg::OP_POP, KEY_BITS'($urandom), pick_tag());
            pace();
        end
        send_cmd(bmh_pkg::OP_POP, KEY_BITS'($urandom), pick_tag());
    endtask

    // Episodes of random traffic, each with its own push/pop balance and key
    // pattern, so the fill level wanders up and down and regularly hits empty.
    task automatic test_random_traffic(int commands);
        int       sent;
        int       episode_len;
        int       push_pct;
        t_key_mix mix;
        sent = 0;
        while (sent < commands) begin
            episode_len = $urandom_range(20, 150);
            if (episode_len > commands - sent) begin
                episode_len = commands - sent;
            end
            case ($urandom_range(0, 3))
                0:       push_pct = 25;
                1:       push_pct = 50;
                2:       push_pct = 70;
                default: push_pct = 90;
            endcase
            mix = pick_mix();
            repeat (episode_len) begin
                if ($urandom_range(1, 100) <= push_pct) begin
                    send_cmd(bmh_pkg::OP_PUSH, pick_key(mix), pick_tag());
                end else begin
                    send_cmd(bmh_pkg::OP_POP, KEY_BITS'($urandom), pick_tag());
                end
                pace();
                sent++;
            end
            // Once in a while hold off until the block has answered everything.
            if ($urandom_range(0, 5) == 0) begin
                drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_edges_and_ties();
        drain_results();
        test_fill_and_overflow();
        drain_results();
        test_random_traffic(RANDOM_COMMANDS);

        // Wait for the last results, then give the block time to show any
        // result that it should not produce.
        start <= 1'b0;
        while (predicted_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
